>>> design/greedy_assortment_select_assert.svh
// Assertion macros for the greedy assortment selector.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef GREEDY_ASSORTMENT_SELECT_ASSERT_SVH
`define GREEDY_ASSORTMENT_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GAS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("gas assertion failed");
`define GAS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("gas assertion failed");
`else
`define GAS_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define GAS_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> design/gas_pkg.sv
// Shared types and constants of the greedy assortment selector.
// No dependencies; imported by gas_div and greedy_assortment_select.
`default_nettype none
package gas_pkg;
   localparam int MAX_CUSTOMERS = 64;
   localparam int MAX_PRODUCTS  = 32;
   localparam int CUST_W        = $clog2(MAX_CUSTOMERS);
   localparam int PROD_W        = $clog2(MAX_PRODUCTS);
   localparam int CELL_AW       = CUST_W + PROD_W;
   localparam int CELL_DEPTH    = MAX_CUSTOMERS * MAX_PRODUCTS;
   localparam int VAL_W         = 32;
   localparam int SUM_W         = 64;
   localparam int FRAC_SHIFT    = 16;
   localparam int RATIO_W       = 48;
   localparam int DVD_W         = SUM_W + FRAC_SHIFT;
   localparam int STEP_W        = $clog2(DVD_W);
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 7;

   localparam logic [1:0] REQ_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_LOAD_CELL   = 2'd1;
   localparam logic [1:0] REQ_START       = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CUSTOMER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRODUCT_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICK_BUDGET    = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [5:0]        customer_index;
      logic [4:0]        product_index;
      logic [VAL_W-1:0]  no_buy_weight;
      logic [VAL_W-1:0]  cell_utility;
      logic [VAL_W-1:0]  cell_revenue;
   } gas_req_type;

   typedef struct packed {
      logic [4:0] picked_product;
      logic       last_pick;
   } gas_rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_ALPHA_WR = 8'b0000_0010,
      ST_CAND     = 8'b0000_0100,
      ST_CUST_RD  = 8'b0000_1000,
      ST_CUST_MUL = 8'b0001_0000,
      ST_PROD     = 8'b0010_0000,
      ST_DIV      = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } gas_state_type;
endpackage
`default_nettype wire

>>> design/gas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wen,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> design/gas_div.sv
// Bit-serial restoring divider: (num << 16) / den, saturated to 48 bits.
// Depends on gas_pkg.
`default_nettype none
module gas_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [gas_pkg::SUM_W-1:0]   num,
   input  wire logic [gas_pkg::SUM_W-1:0]   den,
   output logic                             done,
   output logic      [gas_pkg::RATIO_W-1:0] ratio
);
   import gas_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   den_ff, den_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic               ovf_ff, ovf_in;
   logic [SUM_W:0]     trial;
   logic [SUM_W:0]     diff;
   logic               ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         dvd_in  = {num, {FRAC_SHIFT{1'b0}}};
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         step_in = '0;
         // zero denominator gives a zero ratio right away
         busy_in = (den != '0);
         done_in = (den == '0);
      end else if (busy_ff) begin
         rem_in  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in  = {quo_ff[RATIO_W-2:0], ge};
         ovf_in  = ovf_ff | quo_ff[RATIO_W-1];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
   end

   assign done  = done_ff;
   assign ratio = ovf_ff ? {RATIO_W{1'b1}} : quo_ff;
endmodule
`default_nettype wire

>>> design/greedy_assortment_select.sv
// Greedy assortment selector under a multinomial-logit choice model.
// Channels: req (valid/ready) carries load and start items, rsp (valid/ready)
// carries one item per greedy pick, csr is a plain write port for
// customer_count, product_count and pick_budget (write only while idle).
// A weight load writes straight through; a cell load also passes through the
// alpha write state (alpha read-modify-write through the alpha memory).
// A start runs passes; each pass scores every unchosen product, and each
// score walks all customers: per customer, one cell memory read per product,
// pipeline drain, and the 80-step serial divider with its done cycle.
// Only one item is in work.
// Reset clears the control state, the selection and the alpha valid bits
// (alpha then reads as zero); weights and cells are undefined until loaded.
// A stalled rsp holds the pick in the output register; the engine waits in
// its emit step until the register frees, while loads still see ready only
// when the engine is idle.
`default_nettype none
`include "greedy_assortment_select_assert.svh"
module greedy_assortment_select (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire gas_pkg::gas_req_type             req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output gas_pkg::gas_rsp_type                  rsp_data,
   input  wire logic                             csr_write_en,
   input  wire logic [gas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gas_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gas_pkg::*;

   // configuration
   logic [6:0] cust_cnt_ff;
   logic [5:0] prod_cnt_ff;
   logic [5:0] budget_cfg_ff;
   logic [6:0] nc;
   logic [5:0] np;
   logic [5:0] budget;

   gas_state_type state_ff, state_in;
   logic [MAX_PRODUCTS-1:0]  mask_ff, mask_in;
   logic [5:0]               picks_ff, picks_in;
   logic [5:0]               run_budget_ff, run_budget_in;
   logic [5:0]               cand_ff, cand_in;
   logic [SUM_W-1:0]         best_ff, best_in;
   logic [PROD_W-1:0]        pick_ff, pick_in;
   logic                     have_best_ff, have_best_in;
   logic [SUM_W-1:0]         total_ff, total_in;
   logic [CUST_W:0]          cust_ff, cust_in;
   logic [PROD_W:0]          prod_ff, prod_in;
   logic [VAL_W-1:0]         alpha_ff, alpha_in;
   logic [SUM_W-1:0]         num_ff, num_in;
   logic [SUM_W-1:0]         den_ff, den_in;
   logic                     rd_v_ff, rd_v_in;
   logic                     rd_inc_ff, rd_inc_in;
   logic                     s1_v_ff, s1_v_in;
   logic [SUM_W-1:0]         mul_ff, mul_in;
   logic [VAL_W-1:0]         util_ff, util_in;
   logic [CUST_W-1:0]        al_addr_ff, al_addr_in;
   logic [VAL_W-1:0]         al_rev_ff, al_rev_in;
   logic [MAX_CUSTOMERS-1:0] al_valid_ff, al_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   gas_rsp_type              rsp_ff, rsp_in;

   // memory ports
   logic [2*VAL_W-1:0] cell_rdata;
   logic [VAL_W-1:0]   weight_rdata;
   logic [VAL_W-1:0]   alpha_rdata;
   logic [CUST_W-1:0]  alpha_raddr;
   logic               alpha_wen;
   logic [VAL_W-1:0]   alpha_cur;
   logic               req_fire;
   logic               emit_go;
   logic               emit_last;
   logic               div_start;
   logic               div_done;
   logic [RATIO_W-1:0] div_ratio;
   logic [VAL_W-1:0]   cell_u;
   logic [VAL_W-1:0]   cell_rv;
   logic [VAL_W-1:0]   diff_d;
   logic [SUM_W:0]     num_sum;

   assign nc     = (cust_cnt_ff > 7'(MAX_CUSTOMERS)) ? 7'(MAX_CUSTOMERS) : cust_cnt_ff;
   assign np     = (prod_cnt_ff > 6'(MAX_PRODUCTS)) ? 6'(MAX_PRODUCTS) : prod_cnt_ff;
   assign budget = (budget_cfg_ff > np) ? np : budget_cfg_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // alpha memory: read at the load's customer when idle, else at the walk
   assign alpha_raddr = (state_ff == ST_IDLE) ? req_data.customer_index : cust_ff[CUST_W-1:0];
   assign alpha_cur   = al_valid_ff[al_addr_ff] ? alpha_rdata : '0;
   assign alpha_wen   = (state_ff == ST_ALPHA_WR) && (al_rev_ff > alpha_cur);

   gas_ram #(.WIDTH(2 * VAL_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
      .clock (clock),
      .wen   (req_fire && (req_data.req_type == REQ_LOAD_CELL)),
      .waddr ({req_data.customer_index, req_data.product_index}),
      .wdata ({req_data.cell_utility, req_data.cell_revenue}),
      .raddr ({cust_ff[CUST_W-1:0], prod_ff[PROD_W-1:0]}),
      .rdata (cell_rdata)
   );

   gas_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CUSTOMERS)) u_weight_ram (
      .clock (clock),
      .wen   (req_fire && (req_data.req_type == REQ_LOAD_WEIGHT)),
      .waddr (req_data.customer_index),
      .wdata (req_data.no_buy_weight),
      .raddr (cust_ff[CUST_W-1:0]),
      .rdata (weight_rdata)
   );

   gas_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CUSTOMERS)) u_alpha_ram (
      .clock (clock),
      .wen   (alpha_wen),
      .waddr (al_addr_ff),
      .wdata (al_rev_ff),
      .raddr (alpha_raddr),
      .rdata (alpha_rdata)
   );

   gas_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .ratio (div_ratio)
   );

   assign cell_u    = cell_rdata[2*VAL_W-1:VAL_W];
   assign cell_rv   = cell_rdata[VAL_W-1:0];
   assign diff_d    = (cell_rv > alpha_ff) ? '0 : (alpha_ff - cell_rv);
   assign num_sum   = {1'b0, num_ff} + {1'b0, mul_ff};
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = ((picks_ff + 6'd1) == run_budget_ff);

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      picks_in      = picks_ff;
      run_budget_in = run_budget_ff;
      cand_in       = cand_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      have_best_in  = have_best_ff;
      total_in      = total_ff;
      cust_in       = cust_ff;
      prod_in       = prod_ff;
      alpha_in      = alpha_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      al_addr_in    = al_addr_ff;
      al_rev_in     = al_rev_ff;
      al_valid_in   = al_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      div_start     = 1'b0;

      // product pipeline: read issue, multiply, accumulate
      rd_v_in   = (state_ff == ST_PROD) && (prod_ff < np);
      rd_inc_in = (prod_ff[PROD_W-1:0] == cand_ff[PROD_W-1:0]) || mask_ff[prod_ff[PROD_W-1:0]];
      s1_v_in   = rd_v_ff && rd_inc_ff;
      mul_in    = 64'(diff_d) * 64'(cell_u);
      util_in   = cell_u;
      if (s1_v_ff) begin
         num_in = num_sum[SUM_W] ? {SUM_W{1'b1}} : num_sum[SUM_W-1:0];
         den_in = den_ff + 64'(util_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.req_type)
                  REQ_LOAD_CELL: begin
                     al_addr_in = req_data.customer_index;
                     al_rev_in  = req_data.cell_revenue;
                     state_in   = ST_ALPHA_WR;
                  end
                  REQ_START: begin
                     mask_in       = '0;
                     picks_in      = '0;
                     run_budget_in = budget;
                     cand_in       = '0;
                     have_best_in  = 1'b0;
                     state_in      = (budget == '0) ? ST_IDLE : ST_CAND;
                  end
                  default: begin
                     // weight loads write straight through; unknown codes drop
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ALPHA_WR: begin
            // mark the entry only once it holds a real value
            if (alpha_wen) begin
               al_valid_in[al_addr_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_CAND: begin
            if (cand_ff == np) begin
               state_in = have_best_ff ? ST_EMIT : ST_IDLE;
            end else if (mask_ff[cand_ff[PROD_W-1:0]]) begin
               cand_in = cand_ff + 6'd1;
            end else begin
               total_in = '0;
               cust_in  = '0;
               state_in = ST_CUST_RD;
            end
         end
         ST_CUST_RD: begin
            if (cust_ff == nc) begin
               // score done: keep the lowest, first index wins ties
               if (!have_best_ff || (total_ff < best_ff)) begin
                  best_in      = total_ff;
                  pick_in      = cand_ff[PROD_W-1:0];
                  have_best_in = 1'b1;
               end
               cand_in  = cand_ff + 6'd1;
               state_in = ST_CAND;
            end else begin
               state_in = ST_CUST_MUL;
            end
         end
         ST_CUST_MUL: begin
            alpha_in = al_valid_ff[cust_ff[CUST_W-1:0]] ? alpha_rdata : '0;
            num_in   = 64'(al_valid_ff[cust_ff[CUST_W-1:0]] ? alpha_rdata : '0)
                       * 64'(weight_rdata);
            den_in   = 64'(weight_rdata);
            prod_in  = '0;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            if (prod_ff < np) begin
               prod_in = prod_ff + 1'b1;
            end else if (!rd_v_ff && !s1_v_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               total_in = total_ff + 64'(div_ratio);
               cust_in  = cust_ff + 1'b1;
               state_in = ST_CUST_RD;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_in.picked_product = pick_ff;
               rsp_in.last_pick      = emit_last;
               rsp_valid_in          = 1'b1;
               mask_in               = mask_ff | (MAX_PRODUCTS'(1) << pick_ff);
               picks_in              = picks_ff + 6'd1;
               cand_in               = '0;
               have_best_in          = 1'b0;
               state_in              = emit_last ? ST_IDLE : ST_CAND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cust_cnt_ff   <= 7'd64;
         prod_cnt_ff   <= 6'd32;
         budget_cfg_ff <= 6'd1;
         mask_ff       <= '0;
         picks_ff      <= '0;
         run_budget_ff <= '0;
         have_best_ff  <= 1'b0;
         al_valid_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_v_ff       <= 1'b0;
         s1_v_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         picks_ff      <= picks_in;
         run_budget_ff <= run_budget_in;
         have_best_ff  <= have_best_in;
         al_valid_ff   <= al_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_v_ff       <= rd_v_in;
         s1_v_ff       <= s1_v_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_CUSTOMER_COUNT: cust_cnt_ff   <= csr_wdata;
               CSR_PRODUCT_COUNT:  prod_cnt_ff   <= csr_wdata[5:0];
               CSR_PICK_BUDGET:    budget_cfg_ff <= csr_wdata[5:0];
               default: begin
                  // no register here: drop the write
               end
            endcase
         end
      end
      cand_ff    <= cand_in;
      best_ff    <= best_in;
      pick_ff    <= pick_in;
      total_ff   <= total_in;
      cust_ff    <= cust_in;
      prod_ff    <= prod_in;
      alpha_ff   <= alpha_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rd_inc_ff  <= rd_inc_in;
      mul_ff     <= mul_in;
      util_ff    <= util_in;
      al_addr_ff <= al_addr_in;
      al_rev_ff  <= al_rev_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the final pick shows only once the whole budget is delivered
   `GAS_ASSERT_IMPLY(a_last_at_budget, clock, reset, rsp_valid_ff && rsp_ff.last_pick, picks_ff == run_budget_ff)
   // a pick about to go out is a real, still unchosen product
   `GAS_ASSERT_IMPLY(a_emit_fresh, clock, reset, state_ff == ST_EMIT, have_best_ff && !mask_ff[pick_ff])
   // the divider only finishes while the engine waits for it
   `GAS_ASSERT_IMPLY(a_div_owner, clock, reset, div_done, state_ff == ST_DIV)
   // an emitted pick lands in the output register
   `GAS_ASSERT_NEXT(a_emit_lands, clock, reset, emit_go, rsp_valid_ff && mask_ff[rsp_ff.picked_product])
endmodule
`default_nettype wire
